[rtl/skp_pkg.sv]
package skp_pkg;

  localparam int unsigned MaxPoses = 4;
  localparam int unsigned OneQ12   = 4096;

  localparam logic [2:0] BindSlot = 3'd4;

  // configuration register indexes
  localparam logic [2:0] RegPoseCount = 3'd0;
  localparam logic [2:0] RegWeight0   = 3'd1;
  localparam logic [2:0] RegWeight3   = 3'd4;
  localparam logic [2:0] RegZeroEps   = 3'd5;

  typedef struct packed {
    logic        [2:0]  pose_slot;
    logic signed [31:0] translation_x;
    logic signed [31:0] translation_y;
    logic signed [31:0] translation_z;
    logic signed [15:0] rotation_w;
    logic signed [15:0] rotation_x;
    logic signed [15:0] rotation_y;
    logic signed [15:0] rotation_z;
    logic               end_of_bone;
  } in_t;

  typedef struct packed {
    logic signed [31:0] blended_tx;
    logic signed [31:0] blended_ty;
    logic signed [31:0] blended_tz;
    logic signed [15:0] blended_qw;
    logic signed [15:0] blended_qx;
    logic signed [15:0] blended_qy;
    logic signed [15:0] blended_qz;
  } out_t;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_SCALE = 11'b000_0000_0010,
    S_EW    = 11'b000_0000_0100,
    S_TERM  = 11'b000_0000_1000,
    S_DOT   = 11'b000_0001_0000,
    S_ACC   = 11'b000_0010_0000,
    S_NORM  = 11'b000_0100_0000,
    S_SQ    = 11'b000_1000_0000,
    S_SQRT  = 11'b001_0000_0000,
    S_DIV   = 11'b010_0000_0000,
    S_EMIT  = 11'b100_0000_0000
  } state_e;

endpackage

[rtl/skeletal_pose_blend_top.sv]
// Pose blender for one bone at a time. Requests are to arrive pose 0 first,
// then the other poses, then the bind pose (slot 4); the block does not
// enforce this order. end_of_bone marks the last one and makes one result:
// saturated Q16.16 translation and a Q1.14 quaternion normalised to unit
// length (a zero quaternion comes out as zero). Weights are Q4.12; if the
// used weights sum above one they are scaled by the reciprocal of the sum,
// if below one the bind pose takes the remainder. All arithmetic runs
// through a single 32x32 multiplier and a small sequencer, so in_ready_o is
// low while a request is worked on. A used pose 1..3 passes through weight
// multiply, terms, dot product and accumulate; pose 0 skips the dot product
// and the bind pose the weight multiply; a skipped pose is only accepted.
// End of bone adds magnitude, squares, square root, a divide per quaternion
// component and emit, which waits while the previous result is still held.
// A configuration write recomputes the weight scale, with a restoring divide
// when the sum exceeds one; no request is taken meanwhile. A finished result
// is held in an output register until taken.
module skeletal_pose_blend_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  skp_pkg::in_t        in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output skp_pkg::out_t       out_res_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  skp_pkg::state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  // configuration
  logic [2:0]  pose_count_q;
  logic [15:0] weight_q [4];
  logic [7:0]  eps_q;

  // weight scaling
  logic [12:0] ws_q, bs_q;
  logic [17:0] sum_q, drem_q;
  logic [12:0] dquo_q;

  // current request
  skp_pkg::in_t item_q;
  logic         first_q;
  logic [12:0]  ew_q;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_q;

  logic signed [47:0] tt_q [3];
  logic signed [17:0] tq_q [4];
  logic signed [51:0] dot_q;
  logic signed [47:0] acc_t_q [3];
  logic signed [31:0] acc_r_q [4];

  // normalisation
  logic [29:0] mag_q [4];
  logic [3:0]  neg_q;
  logic [61:0] ss_q;
  logic [63:0] sqv_q, sqr_q, bit_q;
  logic [31:0] rem_q;
  logic [14:0] dq_q, quo_q;
  logic [1:0]  comp_q;
  logic signed [15:0] qres_q [4];

  skp_pkg::out_t out_q;
  logic          out_valid_q;

  logic        accept, emit;
  logic [2:0]  used;
  logic [17:0] sum_c;
  logic        use_c, first_c;
  logic [15:0] w_c;
  logic signed [31:0] trn [3];
  logic signed [15:0] rot [4];
  logic [2:0]  tix, rix;
  logic [31:0] absr [4];
  logic [31:0] mx;
  logic [18:0] dr2;
  logic [63:0] sq_try;
  logic [45:0] dvd;
  logic [32:0] r2;
  logic [14:0] quo_n;
  logic        dot_pos;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v[47:31] == '0 || v[47:31] == '1) return v[31:0];
    return v[47] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
  endfunction

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == skp_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign emit        = (state_q == skp_pkg::S_EMIT) && (!out_valid_q || out_ready_i);

  assign trn[0] = item_q.translation_x;
  assign trn[1] = item_q.translation_y;
  assign trn[2] = item_q.translation_z;
  assign rot[0] = item_q.rotation_w;
  assign rot[1] = item_q.rotation_x;
  assign rot[2] = item_q.rotation_y;
  assign rot[3] = item_q.rotation_z;

  // poses in use, clamped to 1..MaxPoses
  always_comb begin
    if (pose_count_q == 3'd0) begin
      used = 3'd1;
    end else if (32'(pose_count_q) > skp_pkg::MaxPoses) begin
      used = 3'(skp_pkg::MaxPoses);
    end else begin
      used = pose_count_q;
    end
  end

  always_comb begin
    sum_c = {2'b0, weight_q[0]};
    if (used > 3'd1) sum_c = sum_c + {2'b0, weight_q[1]};
    if (used > 3'd2) sum_c = sum_c + {2'b0, weight_q[2]};
    if (used > 3'd3) sum_c = sum_c + {2'b0, weight_q[3]};
  end

  // request decode
  always_comb begin
    w_c     = weight_q[in_req_i.pose_slot[1:0]];
    use_c   = 1'b0;
    first_c = 1'b0;
    if (in_req_i.pose_slot == skp_pkg::BindSlot) begin
      use_c = (bs_q != 13'd0);
    end else if (in_req_i.pose_slot < used) begin
      first_c = (in_req_i.pose_slot == 3'd0);
      use_c   = first_c || (w_c > {8'b0, eps_q});
    end
  end

  assign tix = cnt_q[2:0] - 3'd1;
  assign rix = cnt_q[2:0] - 3'd3;

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      skp_pkg::S_EW: begin
        mul_a = {16'b0, weight_q[item_q.pose_slot[1:0]]};
        mul_b = {19'b0, ws_q};
      end
      skp_pkg::S_TERM: begin
        mul_b = {19'b0, ew_q};
        if (cnt_q < 6'd3) begin
          mul_a = trn[cnt_q[1:0]];
        end else begin
          mul_a = 32'(rot[rix[1:0]]);
        end
      end
      skp_pkg::S_DOT: begin
        mul_a = acc_r_q[cnt_q[1:0]];
        mul_b = 32'(tq_q[cnt_q[1:0]]);
      end
      skp_pkg::S_SQ: begin
        mul_a = {2'b0, mag_q[cnt_q[1:0]]};
        mul_b = {2'b0, mag_q[cnt_q[1:0]]};
      end
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      absr[i] = acc_r_q[i][31] ? 32'(-acc_r_q[i]) : 32'(acc_r_q[i]);
    end
    mx = absr[0];
    for (int i = 1; i < 4; i++) begin
      if (absr[i] > mx) mx = absr[i];
    end
  end

  assign dr2     = {drem_q, cnt_q == 6'd1};
  assign sq_try  = sqr_q + bit_q;
  assign dvd     = {2'b0, mag_q[comp_q], 14'b0} + {15'b0, sqr_q[31:1]};
  assign r2      = {rem_q, dq_q[14]};
  assign quo_n   = {quo_q[13:0], r2 >= {1'b0, sqr_q[31:0]}};
  assign dot_pos = !dot_q[51] && (dot_q != '0);

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 6'd1;
    unique case (state_q)
      skp_pkg::S_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          if (!use_c) begin
            state_d = in_req_i.end_of_bone ? skp_pkg::S_NORM : skp_pkg::S_IDLE;
          end else if (in_req_i.pose_slot == skp_pkg::BindSlot) begin
            state_d = skp_pkg::S_TERM;
          end else begin
            state_d = skp_pkg::S_EW;
          end
        end
      end
      skp_pkg::S_SCALE: begin
        if (cnt_q == 6'd0 && sum_c <= 18'(skp_pkg::OneQ12)) state_d = skp_pkg::S_IDLE;
        if (cnt_q == 6'd25) state_d = skp_pkg::S_IDLE;
      end
      skp_pkg::S_EW: begin
        if (cnt_q == 6'd1) begin
          state_d = skp_pkg::S_TERM;
          cnt_d   = '0;
        end
      end
      skp_pkg::S_TERM: begin
        if (cnt_q == 6'd7) begin
          state_d = first_q ? skp_pkg::S_ACC : skp_pkg::S_DOT;
          cnt_d   = '0;
        end
      end
      skp_pkg::S_DOT: begin
        if (cnt_q == 6'd4) state_d = skp_pkg::S_ACC;
      end
      skp_pkg::S_ACC: begin
        cnt_d   = '0;
        state_d = item_q.end_of_bone ? skp_pkg::S_NORM : skp_pkg::S_IDLE;
      end
      skp_pkg::S_NORM: begin
        cnt_d   = '0;
        state_d = skp_pkg::S_SQ;
      end
      skp_pkg::S_SQ: begin
        if (cnt_q == 6'd4) begin
          state_d = skp_pkg::S_SQRT;
          cnt_d   = '0;
        end
      end
      skp_pkg::S_SQRT: begin
        if (cnt_q == 6'd32) begin
          state_d = skp_pkg::S_DIV;
          cnt_d   = '0;
        end
      end
      skp_pkg::S_DIV: begin
        if (cnt_q == 6'd15) begin
          cnt_d = '0;
          if (comp_q == 2'd3) state_d = skp_pkg::S_EMIT;
        end
      end
      skp_pkg::S_EMIT: begin
        if (emit) state_d = skp_pkg::S_IDLE;
      end
      default: state_d = skp_pkg::S_IDLE;
    endcase
    // a register write restarts the scale computation
    if (cfg_we_i && cfg_index_i <= skp_pkg::RegZeroEps) begin
      state_d = skp_pkg::S_SCALE;
      cnt_d   = '0;
    end
  end

  // control state, configuration, scales and accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= skp_pkg::S_IDLE;
      cnt_q        <= '0;
      pose_count_q <= 3'd1;
      weight_q[0]  <= 16'(skp_pkg::OneQ12);
      weight_q[1]  <= '0;
      weight_q[2]  <= '0;
      weight_q[3]  <= '0;
      eps_q        <= 8'd1;
      ws_q         <= 13'(skp_pkg::OneQ12);
      bs_q         <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < 3; i++) acc_t_q[i] <= '0;
      for (int i = 0; i < 4; i++) acc_r_q[i] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        if (cfg_index_i == skp_pkg::RegPoseCount) begin
          pose_count_q <= cfg_data_i[2:0];
        end else if (cfg_index_i >= skp_pkg::RegWeight0 &&
                     cfg_index_i <= skp_pkg::RegWeight3) begin
          weight_q[2'(cfg_index_i - skp_pkg::RegWeight0)] <= cfg_data_i;
        end else if (cfg_index_i == skp_pkg::RegZeroEps) begin
          eps_q <= cfg_data_i[7:0];
        end
      end
      if (state_q == skp_pkg::S_SCALE) begin
        if (cnt_q == 6'd0) begin
          bs_q <= (sum_c < 18'(skp_pkg::OneQ12)) ? 13'(18'(skp_pkg::OneQ12) - sum_c) : '0;
          if (sum_c <= 18'(skp_pkg::OneQ12)) ws_q <= 13'(skp_pkg::OneQ12);
        end else if (cnt_q == 6'd25) begin
          ws_q <= {dquo_q[11:0], {1'b0, dr2} >= {2'b0, sum_q}};
        end
      end
      if (state_q == skp_pkg::S_ACC) begin
        for (int i = 0; i < 3; i++) begin
          logic signed [48:0] st;
          st = 49'(acc_t_q[i]) + 49'(tt_q[i]);
          if (first_q)             acc_t_q[i] <= tt_q[i];
          else if (st[48] != st[47]) acc_t_q[i] <= st[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
          else                     acc_t_q[i] <= st[47:0];
        end
        for (int i = 0; i < 4; i++) begin
          logic signed [32:0] tr;
          logic signed [32:0] sr;
          tr = dot_pos ? 33'(tq_q[i]) : -33'(tq_q[i]);
          sr = 33'(acc_r_q[i]) + tr;
          if (first_q)               acc_r_q[i] <= 32'(tq_q[i]);
          else if (sr[32] != sr[31]) acc_r_q[i] <= sr[32] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
          else                       acc_r_q[i] <= sr[31:0];
        end
      end
      if (emit) begin
        for (int i = 0; i < 3; i++) acc_t_q[i] <= '0;
        for (int i = 0; i < 4; i++) acc_r_q[i] <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (accept) begin
      item_q  <= in_req_i;
      first_q <= first_c;
      ew_q    <= bs_q;
      dot_q   <= '0;
    end
    if (state_q == skp_pkg::S_SCALE) begin
      if (cnt_q == 6'd0) begin
        sum_q  <= sum_c;
        drem_q <= '0;
        dquo_q <= '0;
      end else if ({1'b0, dr2} >= {2'b0, sum_q}) begin
        drem_q <= 18'({1'b0, dr2} - {2'b0, sum_q});
        dquo_q <= {dquo_q[11:0], 1'b1};
      end else begin
        drem_q <= dr2[17:0];
        dquo_q <= {dquo_q[11:0], 1'b0};
      end
    end
    if (state_q == skp_pkg::S_EW && cnt_q == 6'd1) ew_q <= prod_q[24:12];
    if (state_q == skp_pkg::S_TERM && cnt_q != 6'd0) begin
      if (tix < 3'd3) tt_q[tix[1:0]] <= prod_q[59:12];
      else            tq_q[2'(tix - 3'd3)] <= prod_q[29:12];
    end
    if (state_q == skp_pkg::S_DOT && cnt_q != 6'd0) dot_q <= dot_q + prod_q[51:0];
    if (state_q == skp_pkg::S_NORM) begin
      // bring the largest magnitude below 2^30
      for (int i = 0; i < 4; i++) begin
        neg_q[i] <= acc_r_q[i][31];
        if (mx[31])      mag_q[i] <= absr[i][31:2];
        else if (mx[30]) mag_q[i] <= absr[i][30:1];
        else             mag_q[i] <= absr[i][29:0];
      end
      ss_q <= '0;
    end
    if (state_q == skp_pkg::S_SQ && cnt_q != 6'd0) ss_q <= ss_q + {2'b0, prod_q[59:0]};
    if (state_q == skp_pkg::S_SQRT) begin
      if (cnt_q == 6'd0) begin
        sqv_q <= {2'b0, ss_q};
        sqr_q <= '0;
        bit_q <= 64'd1 << 62;
      end else begin
        if (sqv_q >= sq_try) begin
          sqv_q <= sqv_q - sq_try;
          sqr_q <= (sqr_q >> 1) + bit_q;
        end else begin
          sqr_q <= sqr_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      comp_q <= '0;
    end
    if (state_q == skp_pkg::S_DIV) begin
      if (cnt_q == 6'd0) begin
        rem_q <= {1'b0, dvd[45:15]};
        dq_q  <= dvd[14:0];
        quo_q <= '0;
      end else begin
        rem_q <= quo_n[0] ? 32'(r2 - {1'b0, sqr_q[31:0]}) : r2[31:0];
        dq_q  <= {dq_q[13:0], 1'b0};
        quo_q <= quo_n;
        if (cnt_q == 6'd15) begin
          if (sqr_q[31:0] == '0)  qres_q[comp_q] <= '0;
          else if (neg_q[comp_q]) qres_q[comp_q] <= -{1'b0, quo_n};
          else                    qres_q[comp_q] <= {1'b0, quo_n};
          comp_q <= comp_q + 2'd1;
        end
      end
    end
    if (emit) begin
      out_q.blended_tx <= sat32(acc_t_q[0]);
      out_q.blended_ty <= sat32(acc_t_q[1]);
      out_q.blended_tz <= sat32(acc_t_q[2]);
      out_q.blended_qw <= qres_q[0];
      out_q.blended_qx <= qres_q[1];
      out_q.blended_qy <= qres_q[2];
      out_q.blended_qz <= qres_q[3];
    end
  end

endmodule
